// ===== src/crt_pkg.sv =====
`default_nettype none

package crt_pkg;

   // field widths
   localparam int MOD_W   = 8;
   localparam int ACC_W   = 64;
   localparam int STAT_W  = 2;

   // shared divider and multiplier sequencing
   localparam int DIV_STEPS = ACC_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int MUL_IDX_W = $clog2(MOD_W);
   localparam int PROD_W    = ACC_W + MOD_W;

   // largest modulus accepted as a solvable term
   localparam logic [15:0] MOD_MAX = 16'd255;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_SOLUTION = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW    = 2'd2;

   typedef struct packed {
      logic [MOD_W-1:0] residue;
      logic             residue_valid;
      logic [MOD_W-1:0] modulus;
      logic             last_term;
   } req_payload_type;

   typedef struct packed {
      logic [ACC_W-1:0]  combined_residue;
      logic [ACC_W-1:0]  combined_modulus;
      logic [STAT_W-1:0] status;
      logic              final_res;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RMOD,
      S_MMOD,
      S_SEARCH,
      S_GCD,
      S_QDIV,
      S_MUL,
      S_COMMIT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/crt_req_if.sv =====
`default_nettype none

interface crt_req_if;
   import crt_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/crt_rsp_if.sv =====
`default_nettype none

interface crt_rsp_if;
   import crt_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/crt_residue_combiner_top.sv =====
`default_nettype none

// channel   dir  width  contents
// req_bus   in   18     residue, residue_valid, modulus, last_term
// rsp_bus   out  131    combined_residue, combined_modulus, status, final_res
//
// one term at a time: acc_residue mod m, then acc_modulus mod m, the residue search,
// the subtractive gcd, the quotient by the gcd, the lcm multiply and the commit;
// the modulo passes, search, gcd and quotient share one 9-bit compare/subtract
// unit, while the lcm multiply has its own shift-add.
// a term arriving with a failed status in effect goes straight to its result.
// reset is synchronous; the accumulator comes up at residue 0, modulus 1.
// a held result beat does not block the next term, only its own result slot.

module crt_residue_combiner_top (
   input wire logic   clock,
   input wire logic   reset,
   crt_req_if.sink    req_bus,
   crt_rsp_if.source  rsp_bus
);
   import crt_pkg::*;

   localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [MUL_IDX_W-1:0] MUL_LAST = MUL_IDX_W'(MOD_W - 1);

   state_type state_ff, state_in;

   // accumulated congruence
   logic [ACC_W-1:0]  acc_residue_ff, acc_residue_in;
   logic [ACC_W-1:0]  acc_modulus_ff, acc_modulus_in;
   logic [STAT_W-1:0] sticky_ff, sticky_in;

   // latched term
   logic [MOD_W-1:0] res_ff, res_in;
   logic [MOD_W-1:0] mi_ff, mi_in;
   logic             last_ff, last_in;

   // working registers
   logic [ACC_W-1:0]  div_ff, div_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MOD_W-1:0]  cur_ff, cur_in;
   logic [MOD_W-1:0]  step_ff, step_in;
   logic [MOD_W-1:0]  k_ff, k_in;
   logic [ACC_W-1:0]  cand_ff, cand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // result slot
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // shared compare/subtract unit
   logic [MOD_W:0]   sub_a;
   logic [MOD_W-1:0] sub_b;
   logic             sub_ge;
   logic [MOD_W-1:0] sub_diff;
   logic [MOD_W-1:0] sub_keep;

   logic req_ready;
   logic req_accept;
   logic out_free;
   logic term_bad;
   logic mul_bit;

   // operand select for the shared unit
   always_comb begin
      case (state_ff)
         S_SEARCH: begin
            sub_a = {1'b0, cur_ff} + {1'b0, step_ff};
            sub_b = mi_ff;
         end
         S_GCD: begin
            sub_a = {1'b0, cur_ff};
            sub_b = step_ff;
         end
         S_QDIV: begin
            sub_a = {rem_ff, div_ff[ACC_W-1]};
            sub_b = cur_ff;
         end
         default: begin
            sub_a = {rem_ff, div_ff[ACC_W-1]};
            sub_b = mi_ff;
         end
      endcase
   end

   assign sub_ge   = sub_a >= {1'b0, sub_b};
   assign sub_diff = MOD_W'(sub_a - {1'b0, sub_b});
   assign sub_keep = sub_ge ? sub_diff : sub_a[MOD_W-1:0];

   assign term_bad = !req_bus.payload.residue_valid
                  || (req_bus.payload.modulus == '0)
                  || (16'(req_bus.payload.modulus) > MOD_MAX)
                  || (req_bus.payload.residue >= req_bus.payload.modulus);

   assign mul_bit = mi_ff[MUL_LAST - cnt_ff[MUL_IDX_W-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (sticky_ff != STATUS_OK || term_bad) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RMOD;
               end
            end
         end
         S_RMOD: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = S_MMOD;
            end
         end
         S_MMOD: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (cur_ff == res_ff) begin
               state_in = S_GCD;
            end else if (k_ff == mi_ff - MOD_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_GCD: begin
            if (step_ff == '0) begin
               state_in = S_QDIV;
            end
         end
         S_QDIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (cnt_ff[MUL_IDX_W-1:0] == MUL_LAST) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      req_accept = req_bus.valid && req_ready;
      out_free   = !rsp_valid_ff || rsp_bus.ready;
   end

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // datapath
   always_comb begin
      acc_residue_in = acc_residue_ff;
      acc_modulus_in = acc_modulus_ff;
      sticky_in      = sticky_ff;
      res_in         = res_ff;
      mi_in          = mi_ff;
      last_in        = last_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      step_in        = step_ff;
      k_in           = k_ff;
      cand_in        = cand_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            // latch the term and load acc_residue into the divider
            if (req_accept) begin
               res_in  = req_bus.payload.residue;
               mi_in   = req_bus.payload.modulus;
               last_in = req_bus.payload.last_term;
               div_in  = acc_residue_ff;
               rem_in  = '0;
               cnt_in  = '0;
               if (sticky_ff == STATUS_OK && term_bad) begin
                  sticky_in = STATUS_NO_SOLUTION;
               end
            end
         end
         S_RMOD: begin
            // restoring remainder, one dividend bit per cycle
            rem_in = sub_keep;
            div_in = {div_ff[ACC_W-2:0], sub_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               cur_in = sub_keep;
               div_in = acc_modulus_ff;
               rem_in = '0;
               cnt_in = '0;
            end
         end
         S_MMOD: begin
            rem_in = sub_keep;
            div_in = {div_ff[ACC_W-2:0], sub_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               step_in = sub_keep;
               k_in    = '0;
               cand_in = acc_residue_ff;
               cnt_in  = '0;
            end
         end
         S_SEARCH: begin
            // walk candidates acc_residue + k*acc_modulus
            if (cur_ff == res_ff) begin
               cur_in = mi_ff;
            end else if (k_ff == mi_ff - MOD_W'(1)) begin
               sticky_in = STATUS_NO_SOLUTION;
            end else begin
               cur_in  = sub_keep;
               cand_in = cand_ff + acc_modulus_ff;
               k_in    = k_ff + MOD_W'(1);
            end
         end
         S_GCD: begin
            // subtractive gcd of m and acc_modulus mod m
            if (step_ff == '0) begin
               div_in = acc_modulus_ff;
               rem_in = '0;
               cnt_in = '0;
            end else if (sub_ge) begin
               cur_in = sub_diff;
            end else begin
               cur_in  = step_ff;
               step_in = cur_ff;
            end
         end
         S_QDIV: begin
            // acc_modulus / gcd, quotient shifts into div_ff
            rem_in = sub_keep;
            div_in = {div_ff[ACC_W-2:0], sub_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               prod_in = '0;
               cnt_in  = '0;
            end
         end
         S_MUL: begin
            // shift-add quotient times m, modulus bits msb first
            prod_in = {prod_ff[PROD_W-2:0], 1'b0}
                    + (mul_bit ? {{MOD_W{1'b0}}, div_ff} : {PROD_W{1'b0}});
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         S_COMMIT: begin
            if (prod_ff[PROD_W-1:ACC_W] != '0) begin
               sticky_in = STATUS_OVERFLOW;
            end else begin
               acc_residue_in = cand_ff;
               acc_modulus_in = prod_ff[ACC_W-1:0];
            end
         end
         S_DONE: begin
            // publish the beat, then clear for a new system after the last term
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.combined_residue = acc_residue_ff;
               rsp_data_in.combined_modulus = acc_modulus_ff;
               rsp_data_in.status           = sticky_ff;
               rsp_data_in.final_res        = last_ff;
               if (last_ff) begin
                  acc_residue_in = '0;
                  acc_modulus_in = ACC_W'(1);
                  sticky_in      = STATUS_OK;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         end
      endcase
   end

   // control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         acc_residue_ff <= '0;
         acc_modulus_ff <= ACC_W'(1);
         sticky_ff      <= STATUS_OK;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         acc_residue_ff <= acc_residue_in;
         acc_modulus_ff <= acc_modulus_in;
         sticky_ff      <= sticky_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      mi_ff       <= mi_in;
      last_ff     <= last_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      cur_ff      <= cur_in;
      step_ff     <= step_in;
      k_ff        <= k_in;
      cand_ff     <= cand_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // accumulated residue always stays below accumulated modulus
   a_acc_order: assert property (@(posedge clock) disable iff (reset)
      acc_residue_ff < acc_modulus_ff)
      else $error("accumulated residue not below accumulated modulus");

   // divider remainder stays below its divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMOD || state_ff == S_MMOD) |-> rem_ff < mi_ff)
      else $error("remainder out of range during modulo pass");

   a_qdiv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QDIV) |-> (cur_ff != '0 && rem_ff < cur_ff))
      else $error("bad gcd divisor or remainder during quotient pass");

   // search residue stays reduced
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> cur_ff < mi_ff)
      else $error("search residue not reduced");

   // failed system freezes the accumulator until its result goes out
   a_sticky_freeze: assert property (@(posedge clock) disable iff (reset)
      (sticky_ff != STATUS_OK && state_ff != S_DONE)
      |=> ($stable(acc_residue_ff) && $stable(acc_modulus_ff)))
      else $error("accumulator changed after a failed term");

endmodule

`default_nettype wire

// ===== tb/crt_residue_combiner_checker.sv =====
`timescale 1ns / 100ps

module crt_residue_combiner_checker (
   input  wire logic clock,
   input  wire logic reset,
   crt_req_if        req_bus,
   crt_rsp_if        rsp_bus,
   output int        fail_count,
   output int        pending_count
);
   import crt_pkg::*;

   // running congruence x = acc_residue_q (mod acc_modulus_q) plus failure status
   logic [ACC_W-1:0]  acc_residue_q;
   logic [ACC_W-1:0]  acc_modulus_q;
   logic [STAT_W-1:0] sticky_q;

   // combined congruences still owed by the block, oldest first
   rsp_payload_type expected_combos_q[$];

   function automatic void clear_accumulator();
      acc_residue_q = '0;
      acc_modulus_q = ACC_W'(1);
      sticky_q      = STATUS_OK;
   endfunction

   function automatic logic [ACC_W-1:0] gcd_of(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] rem;
      while (b != '0) begin
         rem = a % b;
         a   = b;
         b   = rem;
      end
      return a;
   endfunction

   // fold one term into the accumulator and return the combined congruence
   function automatic rsp_payload_type fold_congruence(input req_payload_type term);
      logic [ACC_W-1:0]  m;
      logic [ACC_W-1:0]  cur;
      logic [ACC_W-1:0]  step;
      logic [ACC_W-1:0]  k;
      logic [ACC_W-1:0]  g;
      logic [ACC_W-1:0]  quo;
      logic [PROD_W-1:0] lcm_wide;
      logic              found;
      rsp_payload_type   combo;
      m     = ACC_W'(term.modulus);
      found = 1'b0;
      k     = '0;
      // a failed system stays frozen until its last term
      if (sticky_q == STATUS_OK) begin
         if (!term.residue_valid || m == '0 || m > MOD_MAX || term.residue >= term.modulus) begin
            sticky_q = STATUS_NO_SOLUTION;
         end else begin
            // smallest k with (acc_residue + k*acc_modulus) mod m == residue
            cur  = acc_residue_q % m;
            step = acc_modulus_q % m;
            while (!found && k < m) begin
               if (cur == ACC_W'(term.residue)) begin
                  found = 1'b1;
               end else begin
                  cur = (cur + step) % m;
                  k   = k + 1;
               end
            end
            if (!found) begin
               sticky_q = STATUS_NO_SOLUTION;
            end else begin
               // lcm via gcd, checked against 64 bits before commit
               g        = gcd_of(acc_modulus_q, m);
               quo      = acc_modulus_q / g;
               lcm_wide = PROD_W'(quo) * PROD_W'(m);
               if (lcm_wide[PROD_W-1:ACC_W] != '0) begin
                  sticky_q = STATUS_OVERFLOW;
               end else begin
                  acc_residue_q = acc_residue_q + k * acc_modulus_q;
                  acc_modulus_q = lcm_wide[ACC_W-1:0];
               end
            end
         end
      end
      combo.combined_residue = acc_residue_q;
      combo.combined_modulus = acc_modulus_q;
      combo.status           = sticky_q;
      combo.final_res        = term.last_term;
      if (term.last_term) begin
         clear_accumulator();
      end
      return combo;
   endfunction

   // watch both channels; results are compared before the same-edge term is folded
   always @(posedge clock) begin : watch_beats
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         clear_accumulator();
         expected_combos_q.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (expected_combos_q.size() == 0) begin
               $error("result beat with nothing expected: residue %0d modulus %0d status %0d",
                      got.combined_residue, got.combined_modulus, got.status);
               fail_count++;
            end else begin
               want = expected_combos_q.pop_front();
               if (got.combined_residue !== want.combined_residue) begin
                  $error("combined_residue: expected %0d, got %0d",
                         want.combined_residue, got.combined_residue);
                  fail_count++;
               end
               if (got.combined_modulus !== want.combined_modulus) begin
                  $error("combined_modulus: expected %0d, got %0d",
                         want.combined_modulus, got.combined_modulus);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.final_res !== want.final_res) begin
                  $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_combos_q.insert(expected_combos_q.size(),
                                     fold_congruence(req_bus.payload));
         end
         pending_count <= expected_combos_q.size();
      end
   end

endmodule

// ===== tb/crt_residue_combiner_top_tb.sv =====
`timescale 1ns / 100ps

module crt_residue_combiner_top_tb;
   import crt_pkg::*;

   localparam int RANDOM_TERMS = 830;
   localparam int DRAIN_CYCLES = 800;
   // allow for the slowest term plus long random gaps and stalls on top
   localparam int QUIET_LIMIT  = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   random_terms       = 0;
   int   quiet_cycles       = 0;

   crt_req_if req_bus ();
   crt_rsp_if rsp_bus ();

   crt_residue_combiner_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   crt_residue_combiner_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_payload_type mk_term(input logic [MOD_W-1:0] res,
                                               input logic             ok,
                                               input logic [MOD_W-1:0] m,
                                               input logic             last);
      req_payload_type term;
      term.residue       = res;
      term.residue_valid = ok;
      term.modulus       = m;
      term.last_term     = last;
      return term;
   endfunction

   // one term beat, with random idle cycles ahead of it
   task automatic send_term(input req_payload_type term);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= term;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // one system of congruences, mostly consistent with a random 64-bit secret
   task automatic send_system();
      int               span;
      int               mode;
      int               flavor;
      logic [63:0]      secret;
      logic [MOD_W-1:0] m;
      req_payload_type  term;
      mode   = $urandom_range(99, 0);
      secret = {$urandom(), $urandom()};
      span   = (mode < 15) ? $urandom_range(14, 8) : $urandom_range(6, 1);
      for (int i = 0; i < span; i++) begin
         // large moduli push the lcm toward overflow, small ones keep terms short
         if (mode < 15) begin
            m = MOD_W'($urandom_range(255, 180));
         end else if ($urandom_range(3, 0) != 0) begin
            m = MOD_W'($urandom_range(32, 1));
         end else begin
            m = MOD_W'($urandom_range(255, 1));
         end
         term = mk_term(MOD_W'(secret % m), 1'b1, m, i == span - 1);
         // broken systems: stray residue, missing residue or zero modulus
         if (mode >= 75 && $urandom_range(4, 0) == 0) begin
            flavor = $urandom_range(2, 0);
            case (flavor)
               0: begin
                  term.residue = MOD_W'($urandom_range(254, 0));
               end
               1: begin
                  term.residue_valid = 1'b0;
               end
               default: begin
                  term.modulus = '0;
               end
            endcase
         end
         send_term(term);
         random_terms++;
      end
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int big_primes[9];
      int phase;
      big_primes = '{251, 241, 239, 233, 229, 227, 223, 211, 199};
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single-term extremes and each failing kind of term
      send_term(mk_term(8'd0, 1'b1, 8'd1, 1'b1));
      send_term(mk_term(8'd254, 1'b1, 8'd255, 1'b1));
      send_term(mk_term(8'd17, 1'b0, 8'd40, 1'b1));
      send_term(mk_term(8'd7, 1'b1, 8'd5, 1'b1));
      send_term(mk_term(8'd0, 1'b1, 8'd0, 1'b1));
      // conflicting terms, then a term against the frozen state
      send_term(mk_term(8'd3, 1'b1, 8'd6, 1'b0));
      send_term(mk_term(8'd2, 1'b1, 8'd4, 1'b0));
      send_term(mk_term(8'd1, 1'b1, 8'd7, 1'b1));
      // moduli sharing a factor
      send_term(mk_term(8'd2, 1'b1, 8'd4, 1'b0));
      send_term(mk_term(8'd0, 1'b1, 8'd6, 1'b1));
      // x = -1 against large primes until the lcm passes 64 bits
      foreach (big_primes[i]) begin
         send_term(mk_term(MOD_W'(big_primes[i] - 1), 1'b1, MOD_W'(big_primes[i]), 1'b0));
      end
      send_term(mk_term(8'd3, 1'b1, 8'd7, 1'b1));

      // random systems through the idling phases
      while (random_terms < RANDOM_TERMS) begin
         phase = random_terms * 4 / RANDOM_TERMS;
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 53;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 53;
            end
            default: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 29;
            end
         endcase
         send_system();
      end
      req_bus.valid <= 1'b0;

      // drain
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/crt_pkg.sv
src/crt_req_if.sv
src/crt_rsp_if.sv
src/crt_residue_combiner_top.sv
tb/crt_residue_combiner_checker.sv
tb/crt_residue_combiner_top_tb.sv
